// ----- src/keyed_sidetone_generator_macros.svh -----
// Assertion macros for the keyed sidetone generator.
// Depends on a clk and an arst_n in the scope where they are used.
`ifndef KEYED_SIDETONE_GENERATOR_MACROS_SVH
`define KEYED_SIDETONE_GENERATOR_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define KSG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define KSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/ksg_pkg.sv -----
// Package of the keyed sidetone generator: sizes, codes and the quarter-wave sine ROM.
// Depends on nothing; used by keyed_sidetone_generator.
`default_nettype none

package ksg_pkg;

	localparam int MAX_PERIOD       = 4096;
	localparam int SINE_TABLE_DEPTH = 256;

	localparam int POS_W      = $clog2(MAX_PERIOD);
	localparam int PERIOD_W   = 13;
	localparam int PHASE_W    = 16;
	localparam int VOLUME_W   = 9;
	localparam int FORMAT_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SAMPLE_W   = 16;
	localparam int SINE_IDX_W = $clog2(SINE_TABLE_DEPTH);
	localparam int ROM_W      = 15;

	localparam logic [15:0] AMP_WIDE   = 16'd32767;
	localparam logic [15:0] AMP_NARROW = 16'(32767 >> 8);
	// 256 * 32767, the divisor of the narrow scaling
	localparam int          SCALE_DEN  = 256 * 32767;

	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam longint      ONE_Q30     = 64'sd1073741824;

	typedef enum logic [FORMAT_W-1:0] {
		FMT_U8    = 3'd0,
		FMT_S8    = 3'd1,
		FMT_S16LE = 3'd2,
		FMT_U16LE = 3'd3,
		FMT_S16BE = 3'd4,
		FMT_U16BE = 3'd5
	} fmt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD = 2'd0,
		REG_STEP   = 2'd1,
		REG_VOLUME = 2'd2,
		REG_FORMAT = 2'd3
	} reg_idx_t;

	typedef logic [ROM_W-1:0] sine_rom_t [0:SINE_TABLE_DEPTH];

	// Q30 Taylor series of sin over the first quadrant, rounded to Q15
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] prod;
		longint      sum;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			x    = (64'(i) * PI_HALF_Q30) >> SINE_IDX_W;
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int k = 1; k <= 7; k++) begin
				prod = (term * x2) >> 30;
				case (k)
					1:       term = prod / 64'd6;
					2:       term = prod / 64'd20;
					3:       term = prod / 64'd42;
					4:       term = prod / 64'd72;
					5:       term = prod / 64'd110;
					6:       term = prod / 64'd156;
					default: term = prod / 64'd210;
				endcase
				if ((k & 1) != 0)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
			if (sum < 0)
				sum = 0;
			if (sum > ONE_Q30)
				sum = ONE_Q30;
			rom[i] = ROM_W'(((64'(sum) * 64'd32767) + (64'd1 << 29)) >> 30);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ----- src/keyed_sidetone_generator.sv -----
// Keyed sidetone generator top level: phase/position state, sine lookup, scaling, formatting.
// Depends on ksg_pkg and keyed_sidetone_generator_macros.svh.
//
//   channel | direction | handshake             | payload
//   in      | sink      | in_valid / in_ready   | key
//   out     | source    | out_valid / out_ready | sample, active
//   cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per clock unless out_ready stalls the pipe; each key beat passes the input
// register, then ROM lookup and volume multiply, then scaling and format into the
// result register.
// Position and phase update on the accepting edge, so the next beat needs no wait.
// Each stage holds while the one after it is full and stalled; in_ready drops only
// when all three stages are full and out_ready is low. cfg_ready is always high.
// Reset clears state and loads the register defaults; no clearing pass.
`default_nettype none

`include "keyed_sidetone_generator_macros.svh"

module keyed_sidetone_generator
	import ksg_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire                   key,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [SAMPLE_W-1:0]   sample,
	output logic                  active,
	input  wire                   cfg_valid,
	output logic                  cfg_ready,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data
);

	localparam int PROD_W = VOLUME_W + 1 + 17;
	localparam int NUM_W  = PROD_W + 7;

	// configuration
	logic [PERIOD_W-1:0] period_q;
	logic [PHASE_W-1:0]  step_q;
	logic [VOLUME_W-1:0] volume_q;
	logic [FORMAT_W-1:0] format_q;

	// tone state
	logic [POS_W-1:0]    pos_q;
	logic [PHASE_W-1:0]  phase_q;

	// pipeline
	logic                v_s1, act_s1;
	logic [PHASE_W-1:0]  phase_s1;
	logic                v_s2, act_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic en_out, en_s2, en_s1;
	logic in_fire, tone_on, wrap;
	logic [PERIOD_W-1:0] eff_period;
	logic [PERIOD_W-1:0] pos_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_W'(100);
			step_q   <= PHASE_W'(655);
			volume_q <= VOLUME_W'(256);
			format_q <= FMT_U8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				REG_STEP:   step_q   <= cfg_data[PHASE_W-1:0];
				REG_VOLUME: volume_q <= cfg_data[VOLUME_W-1:0];
				REG_FORMAT: format_q <= cfg_data[FORMAT_W-1:0];
				default: ;
			endcase
		end
	end

	assign en_out   = !out_valid || out_ready;
	assign en_s2    = !v_s2 || en_out;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign in_fire  = in_valid && in_ready;

	// A started period always runs to its wrap
	assign tone_on    = key || (pos_q != '0);
	assign eff_period = (period_q > PERIOD_W'(MAX_PERIOD)) ? PERIOD_W'(MAX_PERIOD) : period_q;
	assign pos_next   = PERIOD_W'({1'b0, pos_q}) + PERIOD_W'(1);
	assign wrap       = pos_next >= eff_period;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= '0;
		end else if (in_fire && tone_on) begin
			if (wrap) begin
				pos_q   <= '0;
				phase_q <= '0;
			end else begin
				pos_q   <= pos_next[POS_W-1:0];
				phase_q <= phase_q + step_q;
			end
		end
	end

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_s1   <= tone_on;
			phase_s1 <= phase_q;
		end
	end

	// stage 2: quarter-wave lookup and volume multiply
	logic [1:0]              quad;
	logic [SINE_IDX_W:0]     idx_raw;
	logic [SINE_IDX_W:0]     rom_idx;
	logic [ROM_W-1:0]        rom_val;
	logic signed [16:0]      sine_val;
	logic signed [PROD_W-1:0] prod;

	assign quad    = phase_s1[PHASE_W-1 -: 2];
	assign idx_raw = {1'b0, phase_s1[PHASE_W-3 -: SINE_IDX_W]};
	assign rom_idx = quad[0] ? ((SINE_IDX_W+1)'(SINE_TABLE_DEPTH) - idx_raw) : idx_raw;
	assign rom_val = SINE_ROM[rom_idx];
	assign sine_val = quad[1] ? -$signed({2'b00, rom_val}) : $signed({2'b00, rom_val});
	// widen both operands so the product keeps all its bits
	assign prod     = $signed({{(PROD_W-VOLUME_W){1'b0}}, volume_q}) * PROD_W'(sine_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			act_s2  <= act_s1;
			prod_s2 <= prod;
		end
	end

	// stage 3: scale to amplitude, saturate, format
	logic                    wide;
	logic signed [27:0]      x_wide;
	logic signed [NUM_W-1:0] num_n;
	logic signed [10:0]      q_n;
	logic signed [24:0]      rem_n;
	logic signed [11:0]      qc_n;
	logic signed [12:0]      x_narrow;
	logic [15:0]             x_val;
	logic [15:0]             amp;
	logic [15:0]             x_signed;
	logic [SAMPLE_W-1:0]     fmt_val;

	assign wide   = format_q >= FMT_S16LE;
	// full amplitude: 32767 * (1 + v*s / (256*32767)) reduces to a shift
	assign x_wide = 28'sd32767 + 28'(prod_s2 >>> 8);

	// narrow amplitude: floor(127*p / (2^23 - 256)); the shift estimate is off by one at most
	assign num_n = (NUM_W'(prod_s2) <<< 7) - NUM_W'(prod_s2);
	assign q_n   = num_n[NUM_W-1:23];
	assign rem_n = $signed({2'b00, num_n[22:0]}) + (25'(q_n) <<< 8);
	always_comb begin
		if (rem_n >= 25'(SCALE_DEN))
			qc_n = 12'(q_n) + 12'sd1;
		else if (rem_n < 0)
			qc_n = 12'(q_n) - 12'sd1;
		else
			qc_n = 12'(q_n);
	end
	assign x_narrow = 13'sd127 + 13'(qc_n);

	always_comb begin
		if (wide) begin
			amp = AMP_WIDE;
			if (x_wide < 0)
				x_val = '0;
			else if (x_wide > 28'sd65534)
				x_val = 16'd65534;
			else
				x_val = x_wide[15:0];
		end else begin
			amp = AMP_NARROW;
			if (x_narrow < 0)
				x_val = '0;
			else if (x_narrow > 13'sd254)
				x_val = 16'd254;
			else
				x_val = {8'd0, x_narrow[7:0]};
		end
	end

	assign x_signed = x_val - amp;

	always_comb begin
		case (format_q)
			FMT_U8:    fmt_val = {8'd0, x_val[7:0]};
			FMT_S8:    fmt_val = {8'd0, x_signed[7:0]};
			FMT_S16LE: fmt_val = x_signed;
			FMT_U16LE: fmt_val = x_val;
			FMT_S16BE: fmt_val = {x_signed[7:0], x_signed[15:8]};
			FMT_U16BE: fmt_val = {x_val[7:0], x_val[15:8]};
			default:   fmt_val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en_out) begin
			out_valid <= v_s2;
		end
	end

	// silence carries a zero sample
	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			active <= act_s2;
			sample <= act_s2 ? fmt_val : '0;
		end
	end

	`KSG_ASSERT_NOW(a_phase_zero_at_start, pos_q == '0, phase_q == '0, "phase nonzero at position zero")
	`KSG_ASSERT_NEXT(a_key_starts_tone, in_fire && key, v_s1 && act_s1, "keyed beat not marked active")
	`KSG_ASSERT_NOW(a_silence_is_zero, out_valid && !active, sample == '0, "silent beat with nonzero sample")
	`KSG_ASSERT_NOW(a_pos_below_max, 1'b1, {1'b0, pos_q} < PERIOD_W'(MAX_PERIOD), "position out of range")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench of keyed_sidetone_generator: queue-fed key driver, register writer and result monitor.
// Depends on ksg_pkg and the RTL; predicts each tone or silence sample with its own sine table.

module tb_top;
	import ksg_pkg::*;

	localparam int     CYCLE_LIMIT = 400000;
	localparam int     HOLD_CYCLES = 300;
	localparam longint HALF_PI_Q30 = 1686629713;
	localparam longint ONE_Q30_TB  = 1073741824;
	localparam longint TONE_DEN    = 256 * 32767;
	// format codes the block does not define; they emit zero samples
	localparam logic [FORMAT_W-1:0] FMT_RSVD6 = 3'd6;
	localparam logic [FORMAT_W-1:0] FMT_RSVD7 = 3'd7;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                active;
	} tone_out_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic                  key       = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [SAMPLE_W-1:0]   sample;
	logic                  active;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	keyed_sidetone_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.active    (active),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register shadows and tone state of the predictor
	logic [PERIOD_W-1:0] period_reg;
	logic [PHASE_W-1:0]  step_reg;
	logic [VOLUME_W-1:0] volume_reg;
	logic [FORMAT_W-1:0] format_reg;
	int                  tone_pos;
	logic [PHASE_W-1:0]  tone_phase;

	int         quarter_sine [0:SINE_TABLE_DEPTH];
	logic       key_backlog [$];
	reg_write_t reg_backlog [$];
	tone_out_t  expected_samples [$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int mismatches    = 0;
	int cycles        = 0;

	event hold_go;
	logic holding = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// quarter-wave table: Q30 Taylor series of sin, rounded to Q15
	initial begin : fill_sine
		longint ang, ang_sq, term, acc;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
			ang    = (longint'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
			ang_sq = (ang * ang) >> 30;
			term   = ang;
			acc    = ang;
			for (int k = 1; k <= 7; k++) begin
				term = ((term * ang_sq) >> 30) / longint'((2 * k) * (2 * k + 1));
				acc  = (k % 2 == 1) ? acc - term : acc + term;
			end
			if (acc < 0)
				acc = 0;
			if (acc > ONE_Q30_TB)
				acc = ONE_Q30_TB;
			quarter_sine[i] = int'((acc * 32767 + (longint'(1) << 29)) >> 30);
		end
	end

	function automatic tone_out_t next_tone_sample(logic key_in);
		tone_out_t res;
		int        quad;
		int        idx;
		longint    amp;
		longint    s;
		longint    num;
		longint    x;
		int        eff;
		logic [15:0] t;
		res = '0;
		if (key_in || tone_pos != 0) begin
			quad = tone_phase[15:14];
			idx  = (int'(tone_phase[13:0]) * SINE_TABLE_DEPTH) >> 14;
			if (quad % 2 == 1)
				idx = SINE_TABLE_DEPTH - idx;
			s   = (quad >= 2) ? -longint'(quarter_sine[idx]) : longint'(quarter_sine[idx]);
			amp = (format_reg >= FMT_S16LE) ? 32767 : 127;
			num = amp * TONE_DEN + amp * longint'(volume_reg) * s;
			if (num < 0)
				num = 0;
			x = num / TONE_DEN;
			if (x > 2 * amp)
				x = 2 * amp;
			case (fmt_t'(format_reg))
				FMT_U8:    res.sample = 16'(x) & 16'h00FF;
				FMT_S8:    res.sample = 16'(x - amp) & 16'h00FF;
				FMT_S16LE: res.sample = 16'(x - amp);
				FMT_U16LE: res.sample = 16'(x);
				FMT_S16BE: begin
					t = 16'(x - amp);
					res.sample = {t[7:0], t[15:8]};
				end
				FMT_U16BE: begin
					t = 16'(x);
					res.sample = {t[7:0], t[15:8]};
				end
				default:   res.sample = '0;
			endcase
			res.active = 1'b1;
			eff = int'(period_reg);
			if (eff < 1)
				eff = 1;
			if (eff > MAX_PERIOD)
				eff = MAX_PERIOD;
			tone_pos++;
			if (tone_pos >= eff) begin
				tone_pos   = 0;
				tone_phase = '0;
			end else begin
				tone_phase = tone_phase + step_reg;
			end
		end
		return res;
	endfunction

	// key driver: predict on every accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			key        <= 1'b0;
			tone_pos   = 0;
			tone_phase = '0;
		end else begin
			if (in_valid && in_ready)
				expected_samples.push_back(next_tone_sample(key));
			if (!in_valid || in_ready) begin
				if (key_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					key      <= key_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
					key      <= 1'($urandom);
				end
			end
		end
	end

	// register writer; shadows follow each accepted write
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid  <= 1'b0;
			cfg_index  <= REG_PERIOD;
			cfg_data   <= '0;
			period_reg = 13'd100;
			step_reg   = 16'd655;
			volume_reg = 9'd256;
			format_reg = FMT_U8;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_PERIOD: period_reg = cfg_data[PERIOD_W-1:0];
					REG_STEP:   step_reg   = cfg_data[PHASE_W-1:0];
					REG_VOLUME: volume_reg = cfg_data[VOLUME_W-1:0];
					REG_FORMAT: format_reg = cfg_data[FORMAT_W-1:0];
					default:    ;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_backlog.size() != 0) begin
					cfg_valid <= 1'b1;
					{cfg_index, cfg_data} <= reg_backlog.pop_front();
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted here in clock cycles
	initial begin : receiver_hold
		forever begin
			@(hold_go);
			holding = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding = 1'b0;
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin : monitor
		tone_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: result with nothing expected: sample %h active %b",
						$time, sample, active);
					mismatches++;
				end else begin
					want = expected_samples.pop_front();
					if (sample !== want.sample) begin
						$display("%0t: sample mismatch: expected %h actual %h",
							$time, want.sample, sample);
						mismatches++;
					end
					if (active !== want.active) begin
						$display("%0t: active mismatch: expected %b actual %b",
							$time, want.active, active);
						mismatches++;
					end
				end
			end
			if (holding)
				out_ready <= 1'b0;
			else
				out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic wait_idle();
		@(negedge clk);
		while (key_backlog.size() != 0 || in_valid || expected_samples.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		wait_idle();
		reg_backlog.push_back({idx, data});
		@(negedge clk);
		while (reg_backlog.size() != 0 || cfg_valid)
			@(negedge clk);
	endtask

	task automatic set_traffic(input idle_mode_t mode);
		send_idle_pct = (mode == IDLE_SENDER) ? 84 : (mode == IDLE_BOTH) ? 26 : 0;
		stall_pct     = (mode == IDLE_RECEIVER) ? 84 : (mode == IDLE_BOTH) ? 26 : 0;
	endtask

	// push n keys, first one from the highest bit
	task automatic send_pattern(input logic [15:0] keys, input int n);
		for (int j = n - 1; j >= 0; j--)
			key_backlog.push_back(keys[j]);
	endtask

	// mostly key-down bursts followed by release gaps, some random noise
	task automatic queue_keys(input int n);
		int pushed;
		int on_len;
		int off_len;
		bit noise;
		pushed = 0;
		while (pushed < n) begin
			noise   = ($urandom_range(99) < 15);
			on_len  = $urandom_range(1, 16);
			off_len = $urandom_range(0, 12);
			for (int j = 0; j < on_len + off_len && pushed < n; j++) begin
				key_backlog.push_back(noise ? 1'($urandom) : (j < on_len));
				pushed++;
			end
		end
	endtask

	initial begin : stimulus
		int per;
		int stp;
		int vol;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_traffic(IDLE_NONE);

		// reset settings: silence, a keyed tick, then the period runs on after release
		send_pattern(16'b001000, 6);
		// lower the period below the running position: wrap after the next sample
		write_reg(REG_PERIOD, 16'd2);
		send_pattern(16'b00, 2);
		// period zero wraps every sample; volume above full scale saturates
		write_reg(REG_PERIOD, 16'd0);
		write_reg(REG_STEP, 16'd32768);
		write_reg(REG_VOLUME, 16'd511);
		write_reg(REG_FORMAT, FMT_U16BE);
		send_pattern(16'b110, 3);
		// period above the maximum, zero volume, signed 8-bit
		write_reg(REG_PERIOD, 16'h1FFF);
		write_reg(REG_STEP, 16'd16);
		write_reg(REG_VOLUME, 16'd0);
		write_reg(REG_FORMAT, FMT_S8);
		send_pattern(16'b11, 2);
		// undefined formats keep timing but emit zero
		write_reg(REG_FORMAT, FMT_RSVD7);
		send_pattern(16'b1, 1);
		write_reg(REG_FORMAT, FMT_RSVD6);
		send_pattern(16'b1, 1);
		write_reg(REG_PERIOD, 16'd3);
		write_reg(REG_STEP, 16'd21845);
		write_reg(REG_VOLUME, 16'd256);
		write_reg(REG_FORMAT, FMT_S16LE);
		send_pattern(16'b1000, 4);
		// one sample per quadrant, including the mirrored table end
		write_reg(REG_PERIOD, 16'd4);
		write_reg(REG_STEP, 16'd16384);
		write_reg(REG_FORMAT, FMT_U16LE);
		send_pattern(16'b1111, 4);

		for (int p = 0; p < 12; p++) begin
			case ($urandom_range(9))
				0:       per = 0;
				1:       per = 1;
				2:       per = 2;
				3:       per = MAX_PERIOD;
				4:       per = 8191;
				5:       per = $urandom_range(MAX_PERIOD + 1, 8191);
				6:       per = $urandom_range(41, MAX_PERIOD);
				default: per = $urandom_range(2, 40);
			endcase
			case ($urandom_range(5))
				0:       stp = 16;
				1:       stp = 32768;
				2:       stp = $urandom_range(0, 65535);
				3:       stp = $urandom_range(16, 32768);
				default: stp = (per >= 2 && per <= MAX_PERIOD) ? 65536 / per : 655;
			endcase
			case ($urandom_range(4))
				0:       vol = 0;
				1:       vol = 256;
				2:       vol = 511;
				default: vol = $urandom_range(0, 511);
			endcase
			write_reg(REG_PERIOD, {3'($urandom), 13'(per)});
			write_reg(REG_STEP, 16'(stp));
			write_reg(REG_VOLUME, {7'($urandom), 9'(vol)});
			write_reg(REG_FORMAT, {13'($urandom), 3'(p % 8)});
			set_traffic(idle_mode_t'(p % 4));
			// long receiver hold-off while keys keep coming: fill the pipe
			if (p == 4 || p == 8)
				-> hold_go;
			queue_keys($urandom_range(55, 75));
		end

		wait_idle();
		repeat (12) @(posedge clk);
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
